/* hw/rtl/ssks_pkg.sv */
// Shared types and constants for the sparse Sinkhorn-Knopp scaler.
// No dependencies; imported by sparse_sinkhorn_knopp_scaler.
`default_nettype none

package ssks_pkg;

    // fixed field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 14;
    localparam int VAL_W   = 14;
    localparam int PTR_W   = 14;
    localparam int LIST_W  = 10;
    localparam int FACT_W  = 32;
    localparam int SWEEP_W = 6;
    localparam int MSIZE_W = 11;
    localparam int SCNT_W  = 7;

    localparam logic [FACT_W-1:0] ONE_Q      = 32'h0100_0000;
    localparam logic [SCNT_W-1:0] MAX_SWEEPS = 7'd64;

    // request opcodes
    localparam logic [OP_W-1:0] OP_ROW_PTR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ROW_LIST = 3'd1;
    localparam logic [OP_W-1:0] OP_COL_PTR  = 3'd2;
    localparam logic [OP_W-1:0] OP_COL_LIST = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN      = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_ROW   = 3'd5;
    localparam logic [OP_W-1:0] OP_RD_COL   = 3'd6;

    // configuration register indexes
    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_SWEEP_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,   // clearing pass after reset
        ST_IDLE,
        ST_RCLR,    // factor reset at the start of a run
        ST_PA,      // read pointer i
        ST_PB,      // read pointer i+1
        ST_PC,      // form span
        ST_LA,      // read list entry
        ST_LB,      // check number, read source factor
        ST_LC,      // accumulate or multiply
        ST_LD,      // accumulate rounded product
        ST_FIN,     // end of row
        ST_DIV,     // reciprocal, one quotient bit a cycle
        ST_WB,      // write new factor
        ST_RD,      // factor read data returns
        ST_OUT      // result waits for the receiver
    } state_t;

    typedef enum logic [1:0] {
        PH_ROW,
        PH_COL,
        PH_ERR
    } phase_t;

endpackage

`default_nettype wire

/* hw/rtl/sparse_sinkhorn_knopp_scaler.sv */
// Sparse Sinkhorn-Knopp scaler: pattern stores, factor stores and sequencer.
// Depends on ssks_pkg.
//
// Usage:
//   s_ channel carries requests: s_tuser = opcode, s_tdata = index, value.
//   Load requests (pointer / list writes) are taken one per cycle while
//   idle and give no result. A read request gives one result; an in-range
//   read passes through ST_RD before ST_OUT. A run request resets all
//   factors (one factor address a cycle) and then performs the sweeps. Per
//   sweep, each row and column fetches its pointers and walks its nonzeros,
//   and a row or column with nonzero sum adds a DVW-step restoring divide
//   plus a write of the new factor; the error pass walks each row's nonzeros.
//   The shared divider and the single read port of each store serialize
//   this work. One error result is given per sweep, the last with tlast.
//   After reset the block runs a clearing pass over the factor stores and
//   takes no request until it ends; configuration writes are taken at any
//   time. While m_tready is low, a result holds in the output register and
//   the block waits without accepting requests.
`default_nettype none

module sparse_sinkhorn_knopp_scaler
    import ssks_pkg::*;
#(
    parameter int MAX_SIZE     = 1024,
    parameter int MAX_NONZEROS = 8192
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [10:0] cfg_data,
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // index[13:0], value[27:14], zero pad
    input  wire logic [2:0]  s_tuser,   // opcode
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // number[31:0], sweep[37:32], zero pad
    output logic             m_tuser,   // kind
    output logic             m_tlast    // last
);

    localparam int FAW  = $clog2(MAX_SIZE);
    localparam int PAW  = $clog2(MAX_SIZE + 1);
    localparam int LAW  = $clog2(MAX_NONZEROS);
    localparam int NZW  = $clog2(MAX_NONZEROS + 1);
    localparam int SUMW = FACT_W + NZW;
    localparam int ESW  = 41 + NZW;
    localparam int DVW  = ((SUMW > 49) ? SUMW : 49) + 1;
    localparam int CW   = $clog2(DVW + 1);

    // stores
    logic [PTR_W-1:0]  rptr_mem [MAX_SIZE+1];
    logic [PTR_W-1:0]  cptr_mem [MAX_SIZE+1];
    logic [LIST_W-1:0] rlist_mem [MAX_NONZEROS];
    logic [LIST_W-1:0] clist_mem [MAX_NONZEROS];
    logic [FACT_W-1:0] rfact_mem [MAX_SIZE];
    logic [FACT_W-1:0] cfact_mem [MAX_SIZE];

    logic [PTR_W-1:0]  rptr_rdata, cptr_rdata;
    logic [LIST_W-1:0] rlist_rdata, clist_rdata;
    logic [FACT_W-1:0] rfact_rdata, cfact_rdata;

    // store controls
    logic              rptr_we, cptr_we, rlist_we, clist_we, rfact_we, cfact_we;
    logic [PAW-1:0]    ptr_addr;
    logic [LAW-1:0]    list_addr;
    logic [FAW-1:0]    rfact_addr, cfact_addr;
    logic [FACT_W-1:0] fact_wdata;

    // registers
    state_t            state_reg, state_next;
    phase_t            phase_reg;
    logic [MSIZE_W-1:0] msize_reg;
    logic [SCNT_W-1:0] scnt_reg;
    logic [PAW-1:0]    i_reg;
    logic [NZW-1:0]    k_reg, hi_reg;
    logic [PTR_W-1:0]  lo_reg;
    logic [FACT_W-1:0] r_reg;
    logic [63:0]       prod_reg;
    logic [ESW-1:0]    acc_reg, worst_reg;
    logic [DVW-1:0]    dvd_reg;
    logic [SUMW-1:0]   rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SWEEP_W-1:0] s_reg;
    logic              kind_reg;
    logic [FACT_W-1:0] num_reg;
    logic [OP_W-1:0]   op_reg;

    // request fields
    logic [OP_W-1:0]  in_op;
    logic [IDX_W-1:0] in_idx;
    logic [VAL_W-1:0] in_val;
    logic [31:0]      idx32;
    logic             in_acc;

    assign in_op  = s_tuser;
    assign in_idx = s_tdata[13:0];
    assign in_val = s_tdata[27:14];
    assign idx32  = 32'(in_idx);
    assign in_acc = s_tvalid && s_tready;

    // effective size and sweep count
    logic [PAW-1:0]    n_w;
    logic [SCNT_W-1:0] sweeps_w;
    assign n_w = (32'(msize_reg) > 32'(MAX_SIZE)) ? PAW'(MAX_SIZE) : PAW'(msize_reg);
    assign sweeps_w = (scnt_reg > MAX_SWEEPS) ? MAX_SWEEPS : scnt_reg;

    // selected store data for the current phase
    logic [PTR_W-1:0]  ptr_rdata;
    logic [LIST_W-1:0] list_rdata;
    logic [FACT_W-1:0] src_rdata;
    assign ptr_rdata  = (phase_reg == PH_COL) ? cptr_rdata  : rptr_rdata;
    assign list_rdata = (phase_reg == PH_COL) ? clist_rdata : rlist_rdata;
    assign src_rdata  = (phase_reg == PH_COL) ? rfact_rdata : cfact_rdata;

    // span and loop conditions
    logic [31:0] hi32;
    logic        span_empty, j_ok, k_last, row_last, clr_last, sweep_last;
    assign hi32 = (32'(ptr_rdata) > 32'(MAX_NONZEROS)) ? 32'(MAX_NONZEROS)
                                                       : 32'(ptr_rdata);
    assign span_empty = 32'(lo_reg) >= hi32;
    assign j_ok       = 32'(list_rdata) < 32'(n_w);
    assign k_last     = (32'(k_reg) + 32'd1) >= 32'(hi_reg);
    assign row_last   = (32'(i_reg) + 32'd1) >= 32'(n_w);
    assign clr_last   = i_reg == PAW'(MAX_SIZE - 1);
    assign sweep_last = (7'(s_reg) + 7'd1) == sweeps_w;

    // product rounding and row error
    logic [64:0]  rnd_w;
    logic [40:0]  rnd;
    logic [ESW-1:0] err_w;
    assign rnd_w = 65'(prod_reg) + 65'(24'h80_0000);
    assign rnd   = rnd_w[64:24];
    assign err_w = (acc_reg >= ESW'(ONE_Q)) ? acc_reg - ESW'(ONE_Q)
                                            : ESW'(ONE_Q) - acc_reg;

    // divider step
    logic [SUMW:0]     trial;
    logic              q_bit;
    logic [FACT_W-1:0] q_sat;
    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign q_bit = trial >= {1'b0, acc_reg[SUMW-1:0]};
    assign q_sat = (|dvd_reg[DVW-1:FACT_W]) ? '1 : dvd_reg[FACT_W-1:0];

    // saturated worst error
    logic [FACT_W-1:0] worst_sat;
    assign worst_sat = (|worst_reg[ESW-1:FACT_W]) ? '1 : worst_reg[FACT_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_op)
                        OP_RUN: state_next = ST_RCLR;
                        OP_RD_ROW, OP_RD_COL:
                            state_next = (idx32 < 32'(MAX_SIZE)) ? ST_RD : ST_OUT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RCLR: begin
                if (clr_last) begin
                    if (sweeps_w == '0)     state_next = ST_IDLE;
                    else if (n_w == '0)     state_next = ST_OUT;
                    else                    state_next = ST_PA;
                end
            end
            ST_PA: state_next = ST_PB;
            ST_PB: state_next = ST_PC;
            ST_PC: state_next = span_empty ? ST_FIN : ST_LA;
            ST_LA: state_next = ST_LB;
            ST_LB: begin
                if (j_ok)        state_next = ST_LC;
                else if (k_last) state_next = ST_FIN;
                else             state_next = ST_LA;
            end
            ST_LC: begin
                if (phase_reg == PH_ERR) state_next = ST_LD;
                else                     state_next = k_last ? ST_FIN : ST_LA;
            end
            ST_LD: state_next = k_last ? ST_FIN : ST_LA;
            ST_FIN: begin
                if (phase_reg != PH_ERR && acc_reg != '0) state_next = ST_DIV;
                else if (!row_last)                       state_next = ST_PA;
                else if (phase_reg == PH_ERR)             state_next = ST_OUT;
                else                                      state_next = ST_PA;
            end
            ST_DIV: if (cnt_reg == CW'(DVW - 1)) state_next = ST_WB;
            ST_WB: state_next = ST_PA;
            ST_RD: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    if (kind_reg || sweep_last) state_next = ST_IDLE;
                    else if (n_w == '0)         state_next = ST_OUT;
                    else                        state_next = ST_PA;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // store controls and handshake outputs
    always_comb begin
        rptr_we    = 1'b0;
        cptr_we    = 1'b0;
        rlist_we   = 1'b0;
        clist_we   = 1'b0;
        rfact_we   = 1'b0;
        cfact_we   = 1'b0;
        ptr_addr   = i_reg;
        list_addr  = k_reg[LAW-1:0];
        rfact_addr = i_reg[FAW-1:0];
        cfact_addr = i_reg[FAW-1:0];
        fact_wdata = ONE_Q;
        case (state_reg)
            ST_CLEAR, ST_RCLR: begin
                rfact_we = 1'b1;
                cfact_we = 1'b1;
            end
            ST_IDLE: begin
                ptr_addr   = idx32[PAW-1:0];
                list_addr  = idx32[LAW-1:0];
                rfact_addr = idx32[FAW-1:0];
                cfact_addr = idx32[FAW-1:0];
                if (in_acc) begin
                    case (in_op)
                        OP_ROW_PTR:  rptr_we  = idx32 <= 32'(MAX_SIZE);
                        OP_COL_PTR:  cptr_we  = idx32 <= 32'(MAX_SIZE);
                        OP_ROW_LIST: rlist_we = idx32 < 32'(MAX_NONZEROS);
                        OP_COL_LIST: clist_we = idx32 < 32'(MAX_NONZEROS);
                        default: ;
                    endcase
                end
            end
            ST_PB: ptr_addr = PAW'(32'(i_reg) + 32'd1);
            ST_LB: begin
                rfact_addr = FAW'(32'(list_rdata));
                cfact_addr = FAW'(32'(list_rdata));
            end
            ST_WB: begin
                fact_wdata = q_sat;
                rfact_we   = phase_reg == PH_ROW;
                cfact_we   = phase_reg == PH_COL;
            end
            default: ;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tuser  = kind_reg;
    assign m_tlast  = kind_reg || sweep_last;
    assign m_tdata  = {2'b00, kind_reg ? '0 : s_reg, kind_reg ? num_reg : worst_sat};

    // stores
    always_ff @(posedge aclk) begin
        if (rptr_we) rptr_mem[ptr_addr] <= PTR_W'(in_val);
        rptr_rdata <= rptr_mem[ptr_addr];
    end

    always_ff @(posedge aclk) begin
        if (cptr_we) cptr_mem[ptr_addr] <= PTR_W'(in_val);
        cptr_rdata <= cptr_mem[ptr_addr];
    end

    always_ff @(posedge aclk) begin
        if (rlist_we) rlist_mem[list_addr] <= in_val[LIST_W-1:0];
        rlist_rdata <= rlist_mem[list_addr];
    end

    always_ff @(posedge aclk) begin
        if (clist_we) clist_mem[list_addr] <= in_val[LIST_W-1:0];
        clist_rdata <= clist_mem[list_addr];
    end

    always_ff @(posedge aclk) begin
        if (rfact_we) rfact_mem[rfact_addr] <= fact_wdata;
        rfact_rdata <= rfact_mem[rfact_addr];
    end

    always_ff @(posedge aclk) begin
        if (cfact_we) cfact_mem[cfact_addr] <= fact_wdata;
        cfact_rdata <= cfact_mem[cfact_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msize_reg <= MSIZE_W'(1);
            scnt_reg  <= SCNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MATRIX_SIZE: msize_reg <= cfg_data[MSIZE_W-1:0];
                CFG_SWEEP_COUNT: scnt_reg  <= cfg_data[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_CLEAR, ST_RCLR: i_reg <= clr_last ? '0 : i_reg + PAW'(1);
                ST_IDLE: i_reg <= '0;
                ST_FIN: begin
                    if (phase_reg == PH_ERR || acc_reg == '0)
                        i_reg <= row_last ? '0 : i_reg + PAW'(1);
                end
                ST_WB: i_reg <= row_last ? '0 : i_reg + PAW'(1);
                ST_OUT: i_reg <= '0;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                op_reg   <= in_op;
                kind_reg <= 1'b1;
                num_reg  <= '0;
            end
            ST_RCLR: begin
                s_reg     <= '0;
                phase_reg <= PH_ROW;
                worst_reg <= '0;
                kind_reg  <= 1'b0;
            end
            ST_PB: begin
                lo_reg  <= ptr_rdata;
                r_reg   <= rfact_rdata;
                acc_reg <= '0;
            end
            ST_PC: begin
                k_reg  <= NZW'(lo_reg);
                hi_reg <= NZW'(hi32);
            end
            ST_LB: if (!j_ok) k_reg <= k_reg + NZW'(1);
            ST_LC: begin
                if (phase_reg == PH_ERR) begin
                    prod_reg <= 64'(r_reg) * 64'(src_rdata);
                end else begin
                    acc_reg <= acc_reg + ESW'(src_rdata);
                    k_reg   <= k_reg + NZW'(1);
                end
            end
            ST_LD: begin
                acc_reg <= acc_reg + ESW'(rnd);
                k_reg   <= k_reg + NZW'(1);
            end
            ST_FIN: begin
                if (phase_reg == PH_ERR) begin
                    if (err_w > worst_reg) worst_reg <= err_w;
                end else begin
                    dvd_reg <= (DVW'(1) << 48) + DVW'(acc_reg[SUMW-1:0] >> 1);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                if ((phase_reg == PH_ERR || acc_reg == '0) && row_last) begin
                    if (phase_reg == PH_ROW) phase_reg <= PH_COL;
                    else if (phase_reg == PH_COL) phase_reg <= PH_ERR;
                end
            end
            ST_DIV: begin
                rem_reg <= q_bit ? SUMW'(trial - {1'b0, acc_reg[SUMW-1:0]})
                                 : trial[SUMW-1:0];
                dvd_reg <= {dvd_reg[DVW-2:0], q_bit};
                cnt_reg <= cnt_reg + CW'(1);
            end
            ST_WB: begin
                if (row_last) begin
                    if (phase_reg == PH_ROW) phase_reg <= PH_COL;
                    else phase_reg <= PH_ERR;
                end
            end
            ST_RD: num_reg <= (op_reg == OP_RD_ROW) ? rfact_rdata : cfact_rdata;
            ST_OUT: begin
                if (m_tready && !kind_reg && !sweep_last) begin
                    s_reg     <= s_reg + SWEEP_W'(1);
                    phase_reg <= PH_ROW;
                    worst_reg <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* bench/sparse_sinkhorn_knopp_scaler_tb.sv */
// Self-checking bench for sparse_sinkhorn_knopp_scaler: sparse patterns, runs and reads.
// Depends on ssks_pkg and the scaler RTL; predicts each result from its own copy of the state.
`timescale 1ns / 1ps

module sparse_sinkhorn_knopp_scaler_tb;
    import ssks_pkg::*;

    localparam int MSZ = 1024;
    localparam int MNZ = 8192;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [31:0] number;
        logic [5:0]  sweep;
        logic        last;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [10:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sparse_sinkhorn_knopp_scaler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // predicted block state
    logic [10:0] size_reg;
    logic [6:0]  sweeps_reg;
    logic [13:0] row_ptr [0:MSZ];
    logic [9:0]  row_cols [0:MNZ-1];
    logic [13:0] col_ptr [0:MSZ];
    logic [9:0]  col_rows [0:MNZ-1];
    logic [31:0] row_fac [0:MSZ-1];
    logic [31:0] col_fac [0:MSZ-1];

    result_t pending_results[$];
    int      fail_count;
    int      burst_left;
    int      hold_left;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("sparse_sinkhorn_knopp_scaler_tb: errors");
        $finish;
    end

    function automatic logic [31:0] recip_q(logic [63:0] sum);
        logic [63:0] q;
        q = ((64'd1 << 48) + (sum >> 1)) / sum;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // recompute one side's factors; rows use column factors, columns the new row factors
    function automatic void rescale_side(bit rows, int n);
        int          lo, hi, j;
        logic [63:0] sum;
        for (int i = 0; i < n; i++) begin
            lo = rows ? row_ptr[i] : col_ptr[i];
            hi = rows ? row_ptr[i+1] : col_ptr[i+1];
            if (hi > MNZ) hi = MNZ;
            if (lo >= hi) hi = lo;
            sum = 0;
            for (int k = lo; k < hi; k++) begin
                j = rows ? row_cols[k] : col_rows[k];
                if (j < n) sum += rows ? col_fac[j] : row_fac[j];
            end
            if (sum != 0) begin
                if (rows) row_fac[i] = recip_q(sum);
                else col_fac[i] = recip_q(sum);
            end
        end
    endfunction

    function automatic logic [31:0] worst_row_error(int n);
        int          lo, hi, j;
        logic [63:0] sum, err, worst, p;
        worst = 0;
        for (int i = 0; i < n; i++) begin
            lo = row_ptr[i];
            hi = row_ptr[i+1];
            if (hi > MNZ) hi = MNZ;
            if (lo >= hi) hi = lo;
            sum = 0;
            for (int k = lo; k < hi; k++) begin
                j = row_cols[k];
                if (j < n) begin
                    p = 64'(row_fac[i]) * 64'(col_fac[j]);
                    sum += (p + 64'h80_0000) >> 24;
                end
            end
            err = (sum >= ONE_Q) ? sum - ONE_Q : ONE_Q - sum;
            if (err > worst) worst = err;
        end
        return (worst > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : worst[31:0];
    endfunction

    // state update and expected results of one accepted request
    function automatic void apply_request(logic [2:0] op, logic [13:0] idx, logic [13:0] val);
        int      n, sweeps;
        result_t r;
        case (op)
            OP_ROW_PTR:  if (idx <= MSZ) row_ptr[idx] = val;
            OP_ROW_LIST: if (idx < MNZ) row_cols[idx] = val[9:0];
            OP_COL_PTR:  if (idx <= MSZ) col_ptr[idx] = val;
            OP_COL_LIST: if (idx < MNZ) col_rows[idx] = val[9:0];
            OP_RUN: begin
                n = (size_reg > MSZ) ? MSZ : size_reg;
                sweeps = (sweeps_reg > MAX_SWEEPS) ? MAX_SWEEPS : sweeps_reg;
                for (int i = 0; i < MSZ; i++) begin
                    row_fac[i] = ONE_Q;
                    col_fac[i] = ONE_Q;
                end
                for (int s = 0; s < sweeps; s++) begin
                    rescale_side(1'b1, n);
                    rescale_side(1'b0, n);
                    r.kind = 1'b0;
                    r.number = worst_row_error(n);
                    r.sweep = s[5:0];
                    r.last = (s + 1 == sweeps);
                    pending_results.push_back(r);
                end
            end
            OP_RD_ROW, OP_RD_COL: begin
                r.kind = 1'b1;
                r.number = (idx < MSZ) ? ((op == OP_RD_ROW) ? row_fac[idx] : col_fac[idx]) : 0;
                r.sweep = 0;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // one request, with bursts and gaps on the sender side
    task automatic send_request(logic [2:0] op, logic [13:0] idx, logic [13:0] val);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(op, idx, val);
    endtask

    // wait until the block is idle so that registers may change
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [10:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (addr == CFG_MATRIX_SIZE) size_reg = data;
        else sweeps_reg = data[6:0];
    endtask

    // random n x n pattern in both compressed forms, with skipped and wrapped entries
    task automatic load_pattern(int n);
        bit pat [0:7][0:7];
        int off;
        int dens;
        dens = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                pat[i][j] = ($urandom_range(0, 3) < dens);
        off = $urandom_range(0, 200);
        for (int i = 0; i < n; i++) begin
            send_request(OP_ROW_PTR, i, off);
            for (int j = 0; j < n; j++) if (pat[i][j]) begin
                send_request(OP_ROW_LIST, off, 14'(j | ($urandom_range(0, 15) << 10)));
                off++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_request(OP_ROW_LIST, off, 14'($urandom_range(n, 1023)));
                off++;
            end
        end
        send_request(OP_ROW_PTR, n, off);
        off = $urandom_range(0, 200);
        for (int j = 0; j < n; j++) begin
            send_request(OP_COL_PTR, j, off);
            for (int i = 0; i < n; i++) if (pat[i][j]) begin
                send_request(OP_COL_LIST, off, 14'(i | ($urandom_range(0, 15) << 10)));
                off++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_request(OP_COL_LIST, off, 14'($urandom_range(n, 1023)));
                off++;
            end
        end
        send_request(OP_COL_PTR, n, off);
    endtask

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int mode, mode_left;
        mode_left = 0;
        mode = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    initial begin
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result kind %0d number %h sweep %0d last %0d",
                                 m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[31:0] !== want.number ||
                        m_tdata[37:32] !== want.sweep || m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp kind %0d number %h sweep %0d last %0d, got %0d %h %0d %0d",
                                     want.kind, want.number, want.sweep, want.last,
                                     m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast);
                    end
                end
            end
        end
    end

    // reads straight after reset, out-of-range reads, unused opcode, ignored writes
    task automatic test_reset_reads();
        send_request(OP_RD_ROW, 0, 0);
        send_request(OP_RD_COL, 1023, 14'h3FFF);
        send_request(OP_RD_ROW, 1024, 0);
        send_request(OP_RD_COL, 14'h3FFF, 0);
        send_request(OP_UNUSED, 14'h3FFF, 14'h3FFF);
        send_request(OP_ROW_PTR, 1025, 14'h3FFF);
        send_request(OP_COL_PTR, 14'h3FFF, 0);
        send_request(OP_ROW_LIST, 8192, 5);
        send_request(OP_COL_LIST, 14'h3FFF, 5);
        send_request(OP_RD_ROW, 1, 0);
    endtask

    // empty and reversed spans, clamped span end, wrapped and skipped list entries
    task automatic test_directed_pattern();
        drain_block();
        write_reg(CFG_MATRIX_SIZE, 3);
        write_reg(CFG_SWEEP_COUNT, 3);
        send_request(OP_ROW_PTR, 0, 10000);
        send_request(OP_ROW_PTR, 1, 8190);
        send_request(OP_ROW_PTR, 2, 16000);
        send_request(OP_ROW_PTR, 3, 14'h3FFF);
        send_request(OP_ROW_LIST, 8190, 14'(2 | (3 << 10)));
        send_request(OP_ROW_LIST, 8191, 900);
        send_request(OP_COL_PTR, 0, 0);
        send_request(OP_COL_PTR, 1, 2);
        send_request(OP_COL_PTR, 2, 2);
        send_request(OP_COL_PTR, 3, 3);
        send_request(OP_COL_LIST, 0, 1);
        send_request(OP_COL_LIST, 1, 0);
        send_request(OP_COL_LIST, 2, 14'h2001);
        send_request(OP_RUN, 0, 0);
        for (int i = 0; i < 3; i++) begin
            send_request(OP_RD_ROW, i, 0);
            send_request(OP_RD_COL, i, 0);
        end
    endtask

    // zero size, zero sweeps, oversized sweep count
    task automatic test_edge_registers();
        drain_block();
        write_reg(CFG_MATRIX_SIZE, 0);
        write_reg(CFG_SWEEP_COUNT, 2);
        send_request(OP_RUN, 0, 0);
        drain_block();
        write_reg(CFG_MATRIX_SIZE, 2);
        write_reg(CFG_SWEEP_COUNT, 0);
        load_pattern(2);
        send_request(OP_RUN, 0, 0);
        send_request(OP_RD_ROW, 0, 0);
        drain_block();
        write_reg(CFG_SWEEP_COUNT, 11'h7FF);
        load_pattern(2);
        send_request(OP_RUN, 0, 0);
        send_request(OP_RD_COL, 1, 0);
    endtask

    // random patterns, register settings, reads and noise; one long receiver hold-off
    task automatic test_random_runs();
        int n;
        logic [2:0] op;
        for (int round = 0; round < 2; round++) begin
            drain_block();
            n = $urandom_range(1, 4);
            write_reg(CFG_MATRIX_SIZE, n);
            case ($urandom_range(0, 9))
                0: write_reg(CFG_SWEEP_COUNT, 64);
                1: write_reg(CFG_SWEEP_COUNT, 1);
                default: write_reg(CFG_SWEEP_COUNT, $urandom_range(1, 6));
            endcase
            load_pattern(n);
            send_request(OP_RUN, $urandom, $urandom);
            if (round == 1) hold_left = 400;
            repeat ($urandom_range(3, 10)) begin
                op = ($urandom_range(0, 1) == 0) ? OP_RD_ROW : OP_RD_COL;
                send_request(op, $urandom_range(0, 9), $urandom);
            end
            repeat ($urandom_range(2, 8)) begin
                op = $urandom_range(0, 7);
                if (op == OP_RUN) op = OP_UNUSED;
                send_request(op, $urandom, $urandom);
            end
        end
    endtask

    // all-ones size register with zero sweeps: the run only resets the factors
    task automatic test_full_size();
        drain_block();
        write_reg(CFG_MATRIX_SIZE, 11'h7FF);
        write_reg(CFG_SWEEP_COUNT, 0);
        send_request(OP_RUN, 0, 0);
        send_request(OP_RD_ROW, 1023, 0);
        send_request(OP_RD_COL, 0, 0);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        fail_count = 0;
        burst_left = 0;
        hold_left = 0;
        size_reg = 1;
        sweeps_reg = 1;
        for (int i = 0; i < MSZ; i++) begin
            row_fac[i] = ONE_Q;
            col_fac[i] = ONE_Q;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_reads();
        test_directed_pattern();
        test_edge_registers();
        test_random_runs();
        test_full_size();

        drain_block();
        if (fail_count == 0)
            $display("sparse_sinkhorn_knopp_scaler_tb: clean");
        else
            $display("sparse_sinkhorn_knopp_scaler_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ssks_pkg.sv
hw/rtl/sparse_sinkhorn_knopp_scaler.sv
bench/sparse_sinkhorn_knopp_scaler_tb.sv
